// File: rtl/plr_pkg.sv
// Shared types, codes and port widths of the piecewise linear resampler.
package plr_pkg;

  localparam int IN_TDATA_W  = 64;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_TUSER_W = 2;
  localparam int SAMPLE_W    = 32;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_REWIND = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_INTERP = 2'd0,
    ST_FIRST  = 2'd1,
    ST_LAST   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  // Table read address selection.
  typedef enum logic [1:0] {
    RSEL_WALK,
    RSEL_NEXT,
    RSEL_PREV,
    RSEL_LAST
  } rd_sel_t;

  // Result value selection.
  typedef enum logic [1:0] {
    VSEL_ZERO,
    VSEL_LO,
    VSEL_HI,
    VSEL_ARITH
  } val_sel_t;

  typedef struct packed {
    logic     accept;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     walk_inc;
    logic     cap_hi;
    logic     cap_lo;
    logic     ar_start;
    logic     ld_out;
    val_sel_t val_sel;
    status_t  status;
  } plr_cmd_t;

  typedef struct packed {
    logic is_query;
    logic cnt_zero;
    logic walk_at_end;
    logic next_at_end;
    logic walk_zero;
    logic tq_gt_rd;
    logic tq_le_t0;
    logic hi_clamp;
    logic ar_busy;
    logic out_free;
  } plr_sts_t;

endpackage

// File: rtl/piecewise_linear_resampler_unit.sv
// Top level of the piecewise linear resampler: controller, datapath and stream ports.
//
//  channel | direction | tdata                         | tuser
//  --------+-----------+-------------------------------+-----------------
//  in_     | slave     | [31:0] sample_time            | [1:0] op
//          |           | [63:32] sample_value (Q16.16) |
//  out_    | master    | [31:0] result_value (Q16.16)  | [1:0] status
//
//  Clear, append and rewind are done on acceptance and return no word.
//  A query on an empty series loads its word without reading the table; any
//  other query reads the table from the walk index on to find its neighbor
//  points and, when it interpolates, runs the multiply/divide unit first.
//  Reset (rst_n low, synchronous) empties the series and rewinds the walk.
//  A waiting result stalls only a query that finishes before it drains.
module piecewise_linear_resampler_unit #(
  parameter int MAX_POINTS = 1024,
  parameter int TIME_BITS  = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // slave side
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [plr_pkg::IN_TDATA_W-1:0]  in_tdata,  // sample_time, sample_value
  input  logic [plr_pkg::IN_TUSER_W-1:0]  in_tuser,  // op
  // master side
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [plr_pkg::OUT_TDATA_W-1:0] out_tdata, // result_value
  output logic [plr_pkg::OUT_TUSER_W-1:0] out_tuser  // status
);
  import plr_pkg::*;

  plr_cmd_t cmd;
  plr_sts_t sts;

  // Controller: one state per query phase, drives table reads and loads.
  plr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: table memory, walk index and point count, the two neighbor
  // points, the multiply/divide unit and the output register.
  plr_dpath #(
    .MAX_POINTS (MAX_POINTS),
    .TB         (TIME_BITS),
    .VB         (VALUE_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// File: rtl/plr_muldiv.sv
// Bit-serial multiply then restoring divide: quo = floor(ds * mag / dt), ds < dt.
module plr_muldiv #(
  parameter int TB = 32,
  parameter int VB = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [TB-1:0] ds,
  input  logic [TB-1:0] dt,
  input  logic [VB:0]   mag,
  output logic          busy,
  output logic [VB-1:0] quo
);

  localparam int PW = TB + VB + 1;
  localparam int SW = $clog2(VB + 2);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_MUL,
    PH_DIV
  } phase_t;

  phase_t        phase_r, phase_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic [PW-1:0] acc_r, acc_nxt;
  logic [VB:0]   mag_r, mag_nxt;
  logic [TB-1:0] ds_r, ds_nxt;
  logic [TB-1:0] dt_r, dt_nxt;
  logic [TB:0]   trial;
  logic [TB:0]   diff;
  logic          ge;

  always_comb begin
    trial     = {acc_r[TB+VB-1:VB], acc_r[VB-1]};
    diff      = trial - {1'b0, dt_r};
    ge        = trial >= {1'b0, dt_r};
    phase_nxt = phase_r;
    step_nxt  = step_r;
    acc_nxt   = acc_r;
    mag_nxt   = mag_r;
    ds_nxt    = ds_r;
    dt_nxt    = dt_r;
    case (phase_r)
      PH_IDLE: begin
        if (start) begin
          ds_nxt    = ds;
          dt_nxt    = dt;
          mag_nxt   = mag;
          acc_nxt   = '0;
          step_nxt  = SW'(VB);
          phase_nxt = PH_MUL;
        end
      end
      PH_MUL: begin
        // shift-add, magnitude MSB first
        acc_nxt = (acc_r << 1) + (mag_r[VB] ? PW'(ds_r) : PW'(0));
        mag_nxt = mag_r << 1;
        if (step_r == '0) begin
          step_nxt  = SW'(VB - 1);
          phase_nxt = PH_DIV;
        end else begin
          step_nxt = step_r - SW'(1);
        end
      end
      PH_DIV: begin
        // remainder in the upper bits, quotient shifts in at the bottom
        acc_nxt = {1'b0, (ge ? diff[TB-1:0] : trial[TB-1:0]), acc_r[VB-2:0], ge};
        if (step_r == '0) begin
          phase_nxt = PH_IDLE;
        end else begin
          step_nxt = step_r - SW'(1);
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    acc_r  <= acc_nxt;
    mag_r  <= mag_nxt;
    ds_r   <= ds_nxt;
    dt_r   <= dt_nxt;
  end

  assign busy = (phase_r != PH_IDLE);
  assign quo  = acc_r[VB-1:0];

  // partial remainder must stay below the divisor
  a_rem_below_dt: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DIV) |-> (acc_r[TB+VB-1:VB] < dt_r))
    else $error("remainder not below divisor");

endmodule

// File: rtl/plr_dpath.sv
// Datapath: point table, counters, neighbor registers, arithmetic and result register.
module plr_dpath #(
  parameter int MAX_POINTS = 1024,
  parameter int TB         = 32,
  parameter int VB         = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [plr_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic [plr_pkg::IN_TUSER_W-1:0] in_tuser,
  input  plr_pkg::plr_cmd_t              cmd,
  output plr_pkg::plr_sts_t              sts,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [plr_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [plr_pkg::OUT_TUSER_W-1:0] out_tuser
);
  import plr_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  logic [TB+VB-1:0]      mem [MAX_POINTS];
  logic [TB+VB-1:0]      rd_q_r;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         walk_r, walk_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_value_r;
  status_t               out_status_r;
  logic [TB-1:0]         tq_r, t0_r, t1_r;
  logic signed [VB-1:0]  v0_r, v1_r;
  logic                  neg_r;

  op_t                   in_op;
  logic [TB-1:0]         in_time;
  logic signed [SAMPLE_W-1:0] in_value_raw;
  logic signed [VB-1:0]  in_value;
  logic                  do_write;
  logic [CW-1:0]         addr_full;
  logic [TB-1:0]         rd_time;
  logic [TB-1:0]         dt, ds;
  logic signed [VB:0]    dv;
  logic [VB:0]           mag;
  logic [VB-1:0]         quo;
  logic                  ar_busy;
  logic [VB:0]           res_wide;
  logic signed [VB-1:0]  res_v;
  logic [OUT_TDATA_W-1:0] value_sel;

  assign in_op        = op_t'(in_tuser);
  assign in_time      = TB'(in_tdata[SAMPLE_W-1:0]);
  assign in_value_raw = in_tdata[2*SAMPLE_W-1:SAMPLE_W];
  assign in_value     = VB'(in_value_raw);
  assign do_write     = cmd.accept && (in_op == OP_APPEND) && (count_r < CW'(MAX_POINTS));

  always_comb begin
    count_nxt = count_r;
    walk_nxt  = walk_r;
    if (cmd.accept) begin
      case (in_op)
        OP_CLEAR: begin
          count_nxt = '0;
          walk_nxt  = '0;
        end
        OP_APPEND: begin
          if (do_write) begin
            count_nxt = count_r + CW'(1);
          end
        end
        OP_REWIND: walk_nxt = '0;
        default: ;
      endcase
    end
    if (cmd.walk_inc) begin
      walk_nxt = walk_r + CW'(1);
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      RSEL_WALK: addr_full = walk_r;
      RSEL_NEXT: addr_full = walk_r + CW'(1);
      RSEL_PREV: addr_full = walk_r - CW'(1);
      RSEL_LAST: addr_full = count_r - CW'(1);
      default:   addr_full = walk_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[count_r[AW-1:0]] <= {in_value, in_time};
    end
    if (cmd.rd_en) begin
      rd_q_r <= mem[addr_full[AW-1:0]];
    end
  end

  assign rd_time = rd_q_r[TB-1:0];

  // neighbor differences for the interpolation
  assign dt  = t1_r - t0_r;
  assign ds  = tq_r - t0_r;
  assign dv  = (VB+1)'(v1_r) - (VB+1)'(v0_r);
  assign mag = dv[VB] ? (~dv + 1'b1) : dv;

  plr_muldiv #(
    .TB (TB),
    .VB (VB)
  ) u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.ar_start),
    .ds    (ds),
    .dt    (dt),
    .mag   (mag),
    .busy  (ar_busy),
    .quo   (quo)
  );

  assign res_wide = neg_r ? ((VB+1)'(v0_r) - (VB+1)'(quo))
                          : ((VB+1)'(v0_r) + (VB+1)'(quo));
  assign res_v    = res_wide[VB-1:0];

  always_comb begin
    case (cmd.val_sel)
      VSEL_ZERO:  value_sel = '0;
      VSEL_LO:    value_sel = OUT_TDATA_W'(v0_r);
      VSEL_HI:    value_sel = OUT_TDATA_W'(v1_r);
      VSEL_ARITH: value_sel = OUT_TDATA_W'(res_v);
      default:    value_sel = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.ld_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      walk_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      walk_r      <= walk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      tq_r <= in_time;
    end
    if (cmd.cap_hi) begin
      t1_r <= rd_q_r[TB-1:0];
      v1_r <= rd_q_r[TB+VB-1:TB];
    end
    if (cmd.cap_lo) begin
      t0_r <= rd_q_r[TB-1:0];
      v0_r <= rd_q_r[TB+VB-1:TB];
    end
    if (cmd.ar_start) begin
      neg_r <= dv[VB];
    end
    if (cmd.ld_out) begin
      out_value_r  <= value_sel;
      out_status_r <= cmd.status;
    end
  end

  always_comb begin
    sts.is_query    = (in_op == OP_QUERY);
    sts.cnt_zero    = (count_r == '0);
    sts.walk_at_end = (walk_r == count_r);
    sts.next_at_end = ((walk_r + CW'(1)) == count_r);
    sts.walk_zero   = (walk_r == '0);
    sts.tq_gt_rd    = (tq_r > rd_time);
    sts.tq_le_t0    = (tq_r <= t0_r);
    sts.hi_clamp    = (t1_r <= t0_r) || (tq_r >= t1_r);
    sts.ar_busy     = ar_busy;
    sts.out_free    = !out_valid_r || out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;

  a_walk_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    walk_r <= count_r)
    else $error("walk index beyond point count");

  a_count_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_POINTS))
    else $error("point count beyond capacity");

endmodule

// File: rtl/plr_ctrl.sv
// Controller: sequences the walk, neighbor reads, arithmetic and result load.
module plr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  plr_pkg::plr_sts_t sts,
  output plr_pkg::plr_cmd_t cmd
);
  import plr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_QSTART,
    S_WALK,
    S_LASTRD,
    S_PREVRD,
    S_CHECK,
    S_ARITH,
    S_FIN
  } state_t;

  state_t   state_r, state_nxt;
  status_t  fin_status_r, fin_status_nxt;
  val_sel_t fin_sel_r, fin_sel_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    fin_status_nxt = fin_status_r;
    fin_sel_nxt    = fin_sel_r;
    cmd            = '0;
    cmd.rd_sel     = RSEL_WALK;
    cmd.val_sel    = fin_sel_r;
    cmd.status     = fin_status_r;
    cmd.accept     = in_tvalid && in_tready;
    case (state_r)
      S_IDLE: begin
        if (cmd.accept && sts.is_query) begin
          state_nxt = S_QSTART;
        end
      end
      S_QSTART: begin
        if (sts.cnt_zero) begin
          fin_status_nxt = ST_EMPTY;
          fin_sel_nxt    = VSEL_ZERO;
          state_nxt      = S_FIN;
        end else if (sts.walk_at_end) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RSEL_LAST;
          state_nxt  = S_LASTRD;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RSEL_WALK;
          state_nxt  = S_WALK;
        end
      end
      S_WALK: begin
        if (sts.tq_gt_rd) begin
          cmd.walk_inc = 1'b1;
          if (sts.next_at_end) begin
            // stepped past the last point: the entry in hand is the last one
            cmd.cap_lo     = 1'b1;
            fin_status_nxt = ST_LAST;
            fin_sel_nxt    = VSEL_LO;
            state_nxt      = S_FIN;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RSEL_NEXT;
          end
        end else begin
          cmd.cap_hi = 1'b1;
          if (sts.walk_zero) begin
            fin_status_nxt = ST_FIRST;
            fin_sel_nxt    = VSEL_HI;
            state_nxt      = S_FIN;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RSEL_PREV;
            state_nxt  = S_PREVRD;
          end
        end
      end
      S_LASTRD: begin
        cmd.cap_lo     = 1'b1;
        fin_status_nxt = ST_LAST;
        fin_sel_nxt    = VSEL_LO;
        state_nxt      = S_FIN;
      end
      S_PREVRD: begin
        cmd.cap_lo = 1'b1;
        state_nxt  = S_CHECK;
      end
      S_CHECK: begin
        fin_status_nxt = ST_INTERP;
        if (sts.tq_le_t0) begin
          fin_sel_nxt = VSEL_LO;
          state_nxt   = S_FIN;
        end else if (sts.hi_clamp) begin
          fin_sel_nxt = VSEL_HI;
          state_nxt   = S_FIN;
        end else begin
          cmd.ar_start = 1'b1;
          fin_sel_nxt  = VSEL_ARITH;
          state_nxt    = S_ARITH;
        end
      end
      S_ARITH: begin
        if (!sts.ar_busy) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.ld_out = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fin_status_r <= ST_INTERP;
      fin_sel_r    <= VSEL_ZERO;
    end else begin
      state_r      <= state_nxt;
      fin_status_r <= fin_status_nxt;
      fin_sel_r    <= fin_sel_nxt;
    end
  end

  // clear, append and rewind finish in the accepting cycle
  a_non_query_done: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && !sts.is_query) |=> (state_r == S_IDLE))
    else $error("non-query word left the controller busy");

  // a result is loaded only once the arithmetic unit has settled
  a_load_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_out |-> !sts.ar_busy)
    else $error("result loaded while arithmetic unit busy");

endmodule
